// ===== src/float_ulp_tolerance_compare_top_assert.svh =====
// Assertion macros for the float ULP tolerance compare block
`ifndef FLOAT_ULP_TOLERANCE_COMPARE_TOP_ASSERT_SVH
`define FLOAT_ULP_TOLERANCE_COMPARE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FUC_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FUC_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed");
`else
`define FUC_ASSERT_IMPL(label, clk, rst_n, prop)
`define FUC_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

// ===== src/fuc_pkg.sv =====
// Shared constants and types for the float ULP tolerance compare block
package fuc_pkg;
    localparam int SignPos = 31;
    localparam int FpW = 32;
    localparam int UlpW = 31;
    localparam logic CfgAbs = 1'b0;
    localparam logic CfgUlp = 1'b1;

    // Per-stage side info
    typedef struct packed {
        logic       sign_eq;
        logic       ulp_ok;
        logic       nan_any;
    } side_t;
endpackage

// ===== src/fuc_stage.sv =====
// Pipeline stage register with valid and stall handling (one slot)
module fuc_stage (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_data
);
    logic        valid_reg;
    logic [63:0] data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Load when empty or downstream takes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end
endmodule

// ===== src/fuc_absdiff.sv =====
// Rounded |a-b| compare against tolerance, or same-sign ULP distance check, pipelined across stages
module fuc_absdiff (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] a_bits,
    input  logic [31:0] b_bits,
    input  logic [31:0] tol_bits,
    input  logic [30:0] max_ulps,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        nearly_equal
);
    import fuc_pkg::*;

    // ---- stage 1 logic: order operands by magnitude, align ----
    logic [30:0] ma, mb, big, sml;
    logic        sa, sb, swap;
    logic [7:0]  eb, es, ebx, esx;
    logic [23:0] fb, fs;
    logic [8:0]  ediff;
    logic [31:0] bit_dist;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [63:0] s1_in, s1_out;
    logic        s1_v, s1_r;
    logic [26:0] bigx, smlx;
    logic [49:0] sh;
    logic        stk;

    always_comb
    begin
        sa = a_bits[SignPos];
        sb = b_bits[SignPos];
        ma = a_bits[30:0];
        mb = b_bits[30:0];
        swap = mb > ma;
        big = swap ? mb : ma;
        sml = swap ? ma : mb;
        eb = big[30:23];
        es = sml[30:23];
        ebx = (eb == 8'd0) ? 8'd1 : eb;
        esx = (es == 8'd0) ? 8'd1 : es;
        fb = {eb != 8'd0, big[22:0]};
        fs = {es != 8'd0, sml[22:0]};
        ediff = {1'b0, ebx} - {1'b0, esx};
        a_nan = (a_bits[30:23] == 8'hFF) && (a_bits[22:0] != 23'd0);
        b_nan = (b_bits[30:23] == 8'hFF) && (b_bits[22:0] != 23'd0);
        a_inf = (a_bits[30:23] == 8'hFF) && (a_bits[22:0] == 23'd0);
        b_inf = (b_bits[30:23] == 8'hFF) && (b_bits[22:0] == 23'd0);
        bit_dist = (a_bits > b_bits) ? (a_bits - b_bits) : (b_bits - a_bits);
        bigx = {fb, 3'b000};
        // alignment with sticky, shift capped at 26
        sh = {fs, 26'd0} >> ((ediff > 9'd26) ? 9'd26 : ediff);
        stk = (sh[22:0] != 23'd0) || (ediff > 9'd26 && fs != 24'd0);
        smlx = {sh[49:24], sh[23] | stk};
    end

    // pack: sum1 28, ebx 8, flags
    // a - b subtracts magnitudes when the signs match
    logic eff_sub, nan_any, inf_case, sign_eq, ulp_ok;
    assign eff_sub  = sa ~^ sb;
    assign nan_any  = a_nan || b_nan || (a_inf && b_inf && eff_sub);
    assign inf_case = (a_inf || b_inf) && !nan_any;
    assign sign_eq  = (sa == sb);
    assign ulp_ok   = bit_dist <= {1'b0, max_ulps};

    // sum/diff of aligned significands (28 bits)
    logic [27:0] sum1;
    assign sum1 = eff_sub ? ({1'b0, bigx} - {1'b0, smlx}) : ({1'b0, bigx} + {1'b0, smlx});

    assign s1_in = {sum1, ebx, eff_sub, nan_any, inf_case, sign_eq, ulp_ok, 23'd0};

    fuc_stage u_s1 (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(s1_in), .out_valid(s1_v), .out_ready(s1_r), .out_data(s1_out)
    );

    // ---- stage 2: normalize and round ----
    logic [27:0] s2sum;
    logic [7:0]  s2e;
    logic [4:0]  lz;
    logic [27:0] nrm;
    logic [8:0]  eres;
    logic [22:0] frac;
    logic [24:0] rnd;
    logic [31:0] mag;
    logic        g, r, st;
    logic [4:0]  shl;
    logic [63:0] s2_in, s2_out;
    logic        s2_v, s2_r;

    always_comb
    begin
        s2sum = s1_out[63:36];
        s2e   = s1_out[35:28];
        lz = 5'd27;
        for (int i = 0; i < 28; i++)
        begin
            if (s2sum[i])
            begin
                lz = 5'(27 - i);
            end
        end
        nrm = 28'd0;
        eres = 9'd0;
        shl = 5'd0;
        if (s2sum[27])
        begin
            nrm  = {1'b0, s2sum[27:2], s2sum[1] | s2sum[0]};
            eres = {1'b0, s2e} + 9'd1;
        end
        else
        begin
            // shift left by lz-1 but not below exponent 1; exact zero stays zero
            shl = (lz == 5'd0) ? 5'd0 : lz - 5'd1;
            if ({4'd0, shl} >= {1'b0, s2e} || s2sum == 28'd0)
            begin
                shl = 5'(s2e - 8'd1);
                nrm = s2sum << shl;
                eres = 9'd0; // subnormal or zero
            end
            else
            begin
                nrm = s2sum << shl;
                eres = {1'b0, s2e} - {4'd0, shl};
            end
        end
        g  = nrm[2];
        r  = nrm[1];
        st = nrm[0];
        rnd = {1'b0, nrm[26:3]} + {24'd0, g & (r | st | nrm[3])};
        if (rnd[24])
        begin
            eres = eres + 9'd1;
            frac = rnd[23:1];
        end
        else
        begin
            if (eres == 9'd0 && rnd[23])
            begin
                eres = 9'd1;
            end
            frac = rnd[22:0];
        end
        if (eres >= 9'd255)
        begin
            mag = {1'b0, 8'hFF, 23'd0};
        end
        else
        begin
            mag = {1'b0, eres[7:0], frac};
        end
        if (s1_out[25])
        begin
            mag = {1'b0, 8'hFF, 23'd0};
        end
    end

    assign s2_in = {mag, s1_out[26], s1_out[24:23], 29'd0};

    fuc_stage u_s2 (
        .clk(clk), .rst_n(rst_n), .in_valid(s1_v), .in_ready(s1_r),
        .in_data(s2_in), .out_valid(s2_v), .out_ready(s2_r), .out_data(s2_out)
    );

    // ---- stage 3: float compare with tolerance and final decision ----
    logic [30:0] m3;
    logic        nan3, tol_nan, le, res;
    logic [63:0] s3_in, s3_out;

    always_comb
    begin
        m3 = s2_out[62:32];
        nan3 = s2_out[31];
        tol_nan = (tol_bits[30:23] == 8'hFF) && (tol_bits[22:0] != 23'd0);
        if (nan3 || tol_nan)
        begin
            le = 1'b0;
        end
        else if (!tol_bits[SignPos])
        begin
            le = m3 <= tol_bits[30:0];
        end
        else
        begin
            le = (m3 == 31'd0) && (tol_bits[30:0] == 31'd0);
        end
        res = le || (s2_out[30] && s2_out[29]);
    end

    assign s3_in = {63'd0, res};

    fuc_stage u_s3 (
        .clk(clk), .rst_n(rst_n), .in_valid(s2_v), .in_ready(s2_r),
        .in_data(s3_in), .out_valid(out_valid), .out_ready(out_ready), .out_data(s3_out)
    );

    assign nearly_equal = s3_out[0];
endmodule

// ===== src/float_ulp_tolerance_compare_top.sv =====
// Top level: almost-equal compare of two single-precision values
// Usage:
//   Input channel s_axis: tdata holds a_bits [31:0] and b_bits [63:32].
//   Output channel m_axis: tdata bit 0 is nearly_equal, upper bits zero.
//   Config port: cfg_we with cfg_addr 0 writes max_abs_diff, 1 writes
//   max_ulps (low 31 bits); write only while the pipe is empty.
//   Throughput: one pair per clock while m_axis_tready is high; the three stage registers each hold
//   one item, and each stage's float subtract, normalize/round or
//   compare step sets the per-stage depth.
//   Reset: the pipe empties, max_abs_diff becomes +0.0, max_ulps 4.
//   Stall: when m_axis_tready is low, items stay in the stages and
//   s_axis_tready drops once all stages are full; nothing is lost.
`include "float_ulp_tolerance_compare_top_assert.svh"
module float_ulp_tolerance_compare_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // a_bits[31:0], b_bits[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // nearly_equal[0], zero fill
);
    import fuc_pkg::*;

    logic [31:0] max_abs_diff_reg;
    logic [30:0] max_ulps_reg;
    logic        eq;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_abs_diff_reg <= 32'd0;
            max_ulps_reg     <= 31'd4;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CfgAbs)
            begin
                max_abs_diff_reg <= cfg_wdata;
            end
            else if (cfg_addr == CfgUlp)
            begin
                max_ulps_reg <= cfg_wdata[30:0];
            end
        end
    end

    fuc_absdiff u_core (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .a_bits(s_axis_tdata[31:0]), .b_bits(s_axis_tdata[63:32]),
        .tol_bits(max_abs_diff_reg), .max_ulps(max_ulps_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .nearly_equal(eq)
    );

    assign m_axis_tdata = {7'd0, eq};

    `FUC_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `FUC_ASSERT_IMPL(a_ready, clk, rst_n, (!m_axis_tvalid |-> s_axis_tready))
endmodule
